// ----- rtl/qlcsr_pkg.sv -----
package qlcsr_pkg;

  // Serial frame length and number of converters.
  localparam int PULSES       = 25;
  localparam int CELLS        = 4;
  localparam int READING_BITS = 24;
  localparam int LINE_COUNT   = 4;
  localparam int OUT_CELLS    = 4;
  localparam int CNT_BITS     = $clog2(PULSES + 1);

  typedef enum logic {
    OP_PULSE = 1'b0,
    OP_POLL  = 1'b1
  } op_t;

  typedef logic [READING_BITS-1:0] reading_t;

  typedef struct packed {
    logic                  operation;
    logic [LINE_COUNT-1:0] data_lines;
  } req_t;

  typedef struct packed {
    logic                           clock_enable;
    logic                           sample_valid;
    logic signed [READING_BITS-1:0] cell_front_left;
    logic signed [READING_BITS-1:0] cell_front_right;
    logic signed [READING_BITS-1:0] cell_back_left;
    logic signed [READING_BITS-1:0] cell_back_right;
  } rsp_t;

  typedef struct packed {
    logic shift_en;
    logic deliver;
    logic clock_enable;
    logic running;
    logic pending;
    logic counting;
  } qlcsr_ctrl_t;

endpackage

// ----- rtl/qlcsr_lane.sv -----
module qlcsr_lane
  import qlcsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     shift_en,
  input  logic     line,
  output reading_t reading
);

  logic [PULSES-1:0] sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sr <= '0;
    end else if (shift_en) begin
      sr <= {sr[PULSES-2:0], line};
    end
  end

  // The first bits received sit at the top of the frame.
  assign reading = sr[PULSES-1 -: READING_BITS];

endmodule

// ----- rtl/qlcsr_ctrl.sv -----
module qlcsr_ctrl
  import qlcsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  req_t        req,
  output qlcsr_ctrl_t ctrl
);

  logic [CNT_BITS-1:0] pulse_cnt;
  logic [CNT_BITS-1:0] pulse_cnt_next;
  logic                running;
  logic                running_next;
  logic                pending;
  logic                pending_next;
  logic                lines_low;
  logic                shift_en;
  logic                deliver;

  // Only cells that have a data line can hold the start off.
  always_comb begin
    lines_low = 1'b1;
    for (int i = 0; i < CELLS && i < LINE_COUNT; i++) begin
      if (req.data_lines[i]) begin
        lines_low = 1'b0;
      end
    end
  end

  always_comb begin
    pulse_cnt_next = pulse_cnt;
    running_next   = running;
    pending_next   = pending;
    shift_en       = 1'b0;
    deliver        = 1'b0;
    if (fire) begin
      if (op_t'(req.operation) == OP_PULSE) begin
        if (running) begin
          shift_en = 1'b1;
          if (pulse_cnt == CNT_BITS'(PULSES - 1)) begin
            running_next   = 1'b0;
            pending_next   = 1'b1;
            pulse_cnt_next = '0;
          end else begin
            pulse_cnt_next = pulse_cnt + 1'b1;
          end
        end
      end else begin
        if (pending) begin
          deliver      = 1'b1;
          pending_next = 1'b0;
        end else if (lines_low) begin
          running_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_cnt <= '0;
      running   <= 1'b0;
      pending   <= 1'b0;
    end else begin
      pulse_cnt <= pulse_cnt_next;
      running   <= running_next;
      pending   <= pending_next;
    end
  end

  assign ctrl.shift_en     = shift_en;
  assign ctrl.deliver      = deliver;
  assign ctrl.clock_enable = running_next;
  assign ctrl.running      = running;
  assign ctrl.pending      = pending;
  assign ctrl.counting     = (pulse_cnt != '0);

endmodule

// ----- rtl/qlcsr_merge.sv -----
module qlcsr_merge
  import qlcsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  qlcsr_ctrl_t ctrl,
  input  reading_t    readings [CELLS],
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_data
);

  reading_t ext [OUT_CELLS];
  rsp_t     result;
  rsp_t     skid_data;
  logic     skid_valid;
  logic     out_take;

  genvar g;
  generate
    for (g = 0; g < OUT_CELLS; g++) begin : g_ext
      if (g < CELLS) begin : g_used
        assign ext[g] = ctrl.deliver ? readings[g] : '0;
      end else begin : g_unused
        assign ext[g] = '0;
      end
    end
  endgenerate

  always_comb begin
    result.clock_enable     = ctrl.clock_enable;
    result.sample_valid     = ctrl.deliver;
    result.cell_front_left  = ext[0];
    result.cell_front_right = ext[1];
    result.cell_back_left   = ext[2];
    result.cell_back_right  = ext[3];
  end

  assign out_take = out_valid && !out_stall;
  assign full     = skid_valid;

  // Two-entry output buffer: a new request is taken while a response waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      out_valid  <= skid_valid || fire;
      skid_valid <= 1'b0;
    end else if (fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (fire) begin
      skid_data <= result;
    end
  end

endmodule

// ----- rtl/quad_load_cell_serial_reader_unit.sv -----
// Reader for four 24-bit bridge converters that share one serial clock. Each request is
// either a pulse-ended event or a software poll; every request yields exactly one response
// carrying the clock enable, a sample-valid flag and four signed readings (zero unless the
// poll delivers). One request is taken per clock cycle while in_stall is low, and its
// response is registered; a two-entry output buffer keeps requests flowing while a
// response is stalled, so in_stall only rises when both entries are occupied. Four
// shift-register lanes capture the data lines in parallel under one shared pulse counter.
module quad_load_cell_serial_reader_unit
  import qlcsr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  qlcsr_ctrl_t ctrl;
  reading_t    readings [CELLS];
  logic        full;
  logic        fire;

  assign in_stall = full;
  assign fire     = in_valid && !full;

  qlcsr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (in_data),
    .ctrl (ctrl)
  );

  genvar g;
  generate
    for (g = 0; g < CELLS; g++) begin : g_lane
      logic line;
      if (g < LINE_COUNT) begin : g_line
        assign line = in_data.data_lines[g];
      end else begin : g_low
        assign line = 1'b0;
      end
      qlcsr_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .shift_en (ctrl.shift_en),
        .line     (line),
        .reading  (readings[g])
      );
    end
  endgenerate

  qlcsr_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .ctrl      (ctrl),
    .readings  (readings),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The clock never runs while a finished frame waits for its poll.
  assert property (@(posedge clk) disable iff (rst) !(ctrl.running && ctrl.pending))
    else $error("serial clock running with a result pending");

  // The pulse count is only nonzero in the middle of a frame.
  assert property (@(posedge clk) disable iff (rst) ctrl.counting |-> ctrl.running)
    else $error("pulse count nonzero while the clock is stopped");

  // A delivering poll leaves nothing pending and the clock stopped.
  assert property (@(posedge clk) disable iff (rst)
      ctrl.deliver |=> (!ctrl.pending && !ctrl.running))
    else $error("result still pending after delivery");

endmodule
